// ===== design/stks_pkg.sv =====
// Package for the streaming top-k selector: sizes, data type, cell opcodes,
// the control struct shared by the cell chain and the top level, and FSM states.
// No dependencies.
package stks_pkg;

  localparam int MAX_KEEP = 16;
  localparam int DATA_W   = 32;
  localparam int KEEP_W   = 5;
  localparam int IDX_W    = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
  localparam int CNT_W    = $clog2(MAX_KEEP + 1);
  localparam int CMP_W    = (CNT_W > KEEP_W) ? CNT_W : KEEP_W;

  typedef logic signed [DATA_W-1:0] data_t;

  // config register indexes
  localparam logic REG_KEEP_COUNT  = 1'b0;
  localparam logic REG_SELECT_MODE = 1'b1;

  // per-cycle operation on the sorted (ascending) cell chain
  typedef enum logic [1:0] {
    OP_HOLD     = 2'b00,
    OP_APPEND   = 2'b01,  // insert, chain grows by one
    OP_DROP_MIN = 2'b10,  // insert, smallest entry falls out
    OP_DROP_MAX = 2'b11   // insert, largest entry falls out
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    data_t    sample;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_SCAN = 2'b01,
    ST_EMIT = 2'b10
  } state_e;

endpackage

// ===== design/stks_cell.sv =====
// One cell of the sorted insertion chain: holds one kept value and trades
// values with its neighbors. Depends on stks_pkg.
module stks_cell
  import stks_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       occupied_i,
  input  data_t      left_value_i,
  input  logic       left_gt_i,
  input  data_t      right_value_i,
  input  logic       right_lt_i,
  output data_t      value_o,
  output logic       gt_o,
  output logic       lt_o
);

  data_t value_q, value_d;
  logic  gt_raw, lt_raw;

  assign gt_raw = value_q > ctrl_i.sample;
  assign lt_raw = value_q < ctrl_i.sample;

  // on append an empty cell counts as above every sample
  assign gt_o    = (ctrl_i.op == OP_APPEND) ? (!occupied_i || gt_raw) : (occupied_i && gt_raw);
  assign lt_o    = occupied_i && lt_raw;
  assign value_o = value_q;

  always_comb begin
    value_d = value_q;
    unique case (ctrl_i.op)
      OP_HOLD: begin
        value_d = value_q;
      end
      OP_APPEND, OP_DROP_MAX: begin
        if (gt_o) begin
          value_d = left_gt_i ? left_value_i : ctrl_i.sample;
        end
      end
      OP_DROP_MIN: begin
        if (right_lt_i) begin
          value_d = right_value_i;
        end else if (lt_o) begin
          value_d = ctrl_i.sample;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

// ===== design/streaming_top_k_selector.sv =====
// Top level of the streaming top-k selector: config registers, cell chain,
// emission sequencer and output register. Depends on stks_pkg and stks_cell.
//
// Each sample is sorted into a chain of MAX_KEEP cells in the cycle it is
// accepted, so a set streams in at one item per cycle. The item that carries
// end_of_set starts the emission of the n values kept (n at most MAX_KEEP),
// one value per cycle from the chain through a single read mux; input is not
// accepted during emission, and output back-pressure stretches it. The next
// set may start while the final result still waits.
module streaming_top_k_selector
  import stks_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [KEEP_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  data_t             sample_i,
  input  logic              end_of_set_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output data_t             kept_value_o,
  output logic              final_flag_o
);

  logic [KEEP_W-1:0] keep_count_q;
  logic              select_mode_q;
  state_e            st_q, st_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic              desc_q, desc_d;
  logic              out_valid_q, out_valid_d;
  data_t             out_value_q, out_value_d;
  logic              out_final_q, out_final_d;

  logic [CMP_W-1:0]  kc_ext, k_eff;
  logic              accept, do_append, emit_go;
  cell_ctrl_t        ctrl;
  data_t             value_w [MAX_KEEP];
  logic [MAX_KEEP-1:0] gt_w, lt_w;

  // config
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_count_q  <= KEEP_W'(1);
      select_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_KEEP_COUNT:  keep_count_q  <= cfg_data_i;
        REG_SELECT_MODE: select_mode_q <= cfg_data_i[0];
      endcase
    end
  end

  always_comb begin
    kc_ext = CMP_W'(keep_count_q);
    priority if (kc_ext == '0) begin
      k_eff = CMP_W'(1);
    end else if (kc_ext > CMP_W'(MAX_KEEP)) begin
      k_eff = CMP_W'(MAX_KEEP);
    end else begin
      k_eff = kc_ext;
    end
  end

  assign in_ready_o = (st_q == ST_SCAN);
  assign accept     = in_valid_i && in_ready_o;
  assign do_append  = CMP_W'(total_q) < k_eff;
  assign emit_go    = (st_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctrl.sample = sample_i;
    if (!accept) begin
      ctrl.op = OP_HOLD;
    end else if (do_append) begin
      ctrl.op = OP_APPEND;
    end else if (select_mode_q) begin
      ctrl.op = OP_DROP_MAX;
    end else begin
      ctrl.op = OP_DROP_MIN;
    end
  end

  // chain, ascending from cell 0
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    data_t left_value, right_value;
    logic  left_gt, right_lt;
    if (i == 0) begin : g_first
      assign left_value = sample_i;
      assign left_gt    = 1'b0;
    end else begin : g_mid_l
      assign left_value = value_w[i-1];
      assign left_gt    = gt_w[i-1];
    end
    if (i == MAX_KEEP - 1) begin : g_last
      assign right_value = sample_i;
      assign right_lt    = 1'b0;
    end else begin : g_mid_r
      assign right_value = value_w[i+1];
      assign right_lt    = lt_w[i+1];
    end
    stks_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .occupied_i   (CNT_W'(i) < total_q),
      .left_value_i (left_value),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .right_lt_i   (right_lt),
      .value_o      (value_w[i]),
      .gt_o         (gt_w[i]),
      .lt_o         (lt_w[i])
    );
  end

  // sequencer and output register
  always_comb begin
    st_d        = st_q;
    total_d     = total_q;
    rem_d       = rem_q;
    idx_d       = idx_q;
    desc_d      = desc_q;
    out_valid_d = out_valid_q;
    out_value_d = out_value_q;
    out_final_d = out_final_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (st_q)
      ST_SCAN: begin
        if (accept) begin
          if (do_append) begin
            total_d = total_q + CNT_W'(1);
          end
          if (end_of_set_i) begin
            st_d   = ST_EMIT;
            rem_d  = total_d;
            desc_d = select_mode_q;
            idx_d  = select_mode_q ? IDX_W'(total_d - CNT_W'(1)) : '0;
          end
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_valid_d = 1'b1;
          out_value_d = value_w[idx_q];
          out_final_d = (rem_q == CNT_W'(1));
          rem_d       = rem_q - CNT_W'(1);
          idx_d       = desc_q ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);
          if (rem_q == CNT_W'(1)) begin
            st_d    = ST_SCAN;
            total_d = '0;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_SCAN;
      total_q     <= '0;
      rem_q       <= '0;
      idx_q       <= '0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      total_q     <= total_d;
      rem_q       <= rem_d;
      idx_q       <= idx_d;
      desc_q      <= desc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q <= out_value_d;
    out_final_q <= out_final_d;
  end

  assign out_valid_o  = out_valid_q;
  assign kept_value_o = out_value_q;
  assign final_flag_o = out_final_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_KEEP))
    else $error("kept count above capacity");

  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_EMIT) |-> (rem_q != '0))
    else $error("emission with nothing left");

  a_end_starts_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_set_i) |=> (st_q == ST_EMIT))
    else $error("end of set did not start emission");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && rem_q == CNT_W'(1)) |=> (total_q == '0 && out_valid_o && final_flag_o))
    else $error("final item not marked or store not cleared");

endmodule

// ===== bench/streaming_top_k_selector_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for streaming_top_k_selector: random and directed sets with
// a top-k predictor, ordered check of every emitted value. Uses stks_pkg and the DUT.
module streaming_top_k_selector_test
  import stks_pkg::*;
();

  class topk_scoreboard;
    data_t             kept[MAX_KEEP];
    int unsigned       kept_n;
    logic [KEEP_W-1:0] keep_count;
    logic              select_mode;
    data_t             exp_value_q[$];
    logic              exp_final_q[$];
    int                errors;

    function new();
      kept_n      = 0;
      keep_count  = KEEP_W'(1);
      select_mode = 1'b0;
      errors      = 0;
    endfunction

    function void set_register(logic idx, logic [KEEP_W-1:0] value);
      if (idx == REG_KEEP_COUNT) begin
        keep_count = value;
      end else begin
        select_mode = value[0];
      end
    endfunction

    function bit worse(data_t a, data_t b, logic mode);
      return mode ? (a > b) : (a < b);
    endfunction

    function int pending();
      return exp_value_q.size();
    endfunction

    function void note_sample(data_t value, logic is_last);
      int unsigned k;
      int unsigned w;
      int unsigned n;
      int          j;
      data_t       sorted[MAX_KEEP];
      data_t       key;
      k = (keep_count < 1) ? 1 : ((keep_count > MAX_KEEP) ? MAX_KEEP : keep_count);
      if (kept_n < k && kept_n < MAX_KEEP) begin
        kept[kept_n] = value;
        kept_n++;
      end else if (kept_n > 0) begin
        w = 0;
        for (int i = 1; i < kept_n; i++) begin
          if (worse(kept[i], kept[w], select_mode)) w = i;
        end
        if (worse(kept[w], value, select_mode)) kept[w] = value;
      end
      if (!is_last) return;
      n = kept_n;
      for (int i = 0; i < n; i++) sorted[i] = kept[i];
      for (int i = 1; i < n; i++) begin
        key = sorted[i];
        j   = i;
        while (j > 0 && worse(key, sorted[j-1], select_mode)) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = key;
      end
      for (int i = 0; i < n; i++) begin
        exp_value_q = {exp_value_q, sorted[i]};
        exp_final_q = {exp_final_q, (i + 1 == n)};
      end
      kept_n = 0;
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(data_t value, logic flag);
      data_t exp_value;
      logic  exp_final;
      if (exp_value_q.size() == 0) begin
        report($sformatf("unexpected item value %0d final %0b", value, flag));
        return;
      end
      exp_value = exp_value_q.pop_front();
      exp_final = exp_final_q.pop_front();
      if (value !== exp_value)
        report($sformatf("kept_value %0d, expected %0d", value, exp_value));
      if (flag !== exp_final)
        report($sformatf("final_flag %0b, expected %0b", flag, exp_final));
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic              cfg_idx_i;
  logic [KEEP_W-1:0] cfg_data_i;
  logic              in_valid_i;
  logic              in_ready_o;
  data_t             sample_i;
  logic              end_of_set_i;
  logic              out_valid_o;
  logic              out_ready_i;
  data_t             kept_value_o;
  logic              final_flag_o;

  topk_scoreboard sb;
  int             in_gap_max;
  int             out_stall_max;

  streaming_top_k_selector i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_i     (sample_i),
    .end_of_set_i (end_of_set_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kept_value_o (kept_value_o),
    .final_flag_o (final_flag_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  task send_item(data_t value, logic is_last);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_i     <= value;
    end_of_set_i <= is_last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(value, is_last);
    @(negedge clk_i);
  endtask

  // hold input off until all results are out and the chain has settled
  task wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_config(logic [KEEP_W-1:0] k, logic mode);
    logic [KEEP_W-1:0] mode_word;
    mode_word    = KEEP_W'($urandom);
    mode_word[0] = mode;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_KEEP_COUNT;
    cfg_data_i <= k;
    @(posedge clk_i);
    sb.set_register(REG_KEEP_COUNT, k);
    @(negedge clk_i);
    cfg_idx_i  <= REG_SELECT_MODE;
    cfg_data_i <= mode_word;
    @(posedge clk_i);
    sb.set_register(REG_SELECT_MODE, mode_word);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic data_t random_sample();
    case ($urandom_range(0, 5))
      0:       return data_t'($urandom_range(0, 8)) - 4;
      1: begin
        case ($urandom_range(0, 3))
          0:       return data_t'(32'h7fffffff);
          1:       return data_t'(32'h80000000);
          2:       return '0;
          default: return '1;
        endcase
      end
      2:       return data_t'($urandom_range(0, 40)) - 20;
      default: return data_t'($urandom);
    endcase
  endfunction

  function automatic logic [KEEP_W-1:0] random_keep();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return KEEP_W'(1);
      2:       return KEEP_W'(MAX_KEEP);
      3:       return KEEP_W'($urandom_range(MAX_KEEP + 1, 31));
      default: return KEEP_W'($urandom_range(1, MAX_KEEP));
    endcase
  endfunction

  initial begin
    int stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(kept_value_o, final_flag_o);
      @(negedge clk_i);
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int sent;
    int set_len;
    int split_at;
    sb            = new();
    in_gap_max    = 4;
    out_stall_max = 4;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_KEEP_COUNT;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sample_i      = '0;
    end_of_set_i  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // registers at reset: keep one, largest
    send_item(5, 1'b0);
    send_item(-3, 1'b0);
    send_item(7, 1'b1);
    wait_drained();
    write_config(KEEP_W'(MAX_KEEP), 1'b0);
    send_item(data_t'(32'h7fffffff), 1'b0);
    send_item(data_t'(32'h80000000), 1'b0);
    send_item(0, 1'b0);
    send_item(-1, 1'b0);
    send_item(1, 1'b1);
    wait_drained();
    // full store with duplicates, smallest mode
    write_config(KEEP_W'(3), 1'b1);
    send_item(10, 1'b0);
    send_item(10, 1'b0);
    send_item(-5, 1'b0);
    send_item(20, 1'b0);
    send_item(-5, 1'b0);
    send_item(10, 1'b1);
    wait_drained();
    // zero keep count acts as one
    write_config(KEEP_W'(0), 1'b0);
    send_item(-8, 1'b0);
    send_item(3, 1'b1);
    wait_drained();
    // oversized keep count clamps
    write_config(KEEP_W'(31), 1'b1);
    send_item(2, 1'b0);
    send_item(2, 1'b0);
    send_item(-9, 1'b1);
    send_item(42, 1'b1);
    wait_drained();
    // count lowered and mode flipped mid-set
    write_config(KEEP_W'(4), 1'b0);
    send_item(1, 1'b0);
    send_item(2, 1'b0);
    send_item(3, 1'b0);
    send_item(4, 1'b0);
    wait_drained();
    write_config(KEEP_W'(2), 1'b1);
    send_item(0, 1'b0);
    send_item(9, 1'b1);

    sent = 0;
    while (sent < 400) begin
      if ($urandom_range(0, 3) == 0) begin
        in_gap_max    = 0;
        out_stall_max = 0;
      end else begin
        in_gap_max    = 4;
        out_stall_max = 4;
      end
      if ($urandom_range(0, 2) == 0) begin
        wait_drained();
        write_config(random_keep(), 1'($urandom_range(0, 1)));
      end
      set_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 20);
      split_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, set_len) : 0;
      for (int i = 1; i <= set_len; i++) begin
        if (i == split_at && i != set_len) begin
          wait_drained();
          write_config(random_keep(), 1'($urandom_range(0, 1)));
        end
        send_item(random_sample(), i == set_len);
        sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
